// ===== rtl/rbsa_pkg.sv =====
// rbsa_pkg: request and result types, opcodes and status codes of the
// ring buffer space allocator; no dependencies
package rbsa_pkg;

    localparam int CNT_W = 21;
    localparam int OFS_W = 20;

    localparam logic [1:0] OP_PROBE   = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [CNT_W-1:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFS_W-1:0] start_offset;
        logic             ring_empty;
    } t_rsp;

endpackage

// ===== rtl/ring_buffer_space_allocator_top.sv =====
// ring_buffer_space_allocator_top: bookkeeping for a contiguous-space byte ring
// depends on rbsa_pkg and rbsa_step
//
//   channel   signals                          moves
//   request   i_in_valid / o_in_ready / i_in   t_req transfer
//   result    o_out_valid / i_out_ready / o_out t_rsp transfer
//   config    i_cfg_wr_en / i_cfg_wr_data      ring size write, no wait
//
// one request per cycle while the result side is not stalled; a result is offered from
// the result register once its request has passed the input register and the step logic
// synchronous active-low reset restores a ring of 2^OFFSET_BITS bytes
// a stalled result holds the result register and then the input register
module ring_buffer_space_allocator_top import rbsa_pkg::*; #(
    parameter int OFFSET_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req             i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp             o_out
);

    localparam int PW = OFFSET_BITS + 1;
    localparam int AW = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam logic [AW-1:0] RING_MAX = AW'(1) << OFFSET_BITS;

    logic [PW-1:0] r_ring_size, r_freed_mark, r_write_pos, r_wrap_end;
    logic [AW-1:0] r_bytes_in_use;
    logic          r_in_valid, r_out_valid;
    t_req          r_in;
    t_rsp          r_out;

    logic [PW-1:0] n_freed_mark, n_write_pos, n_wrap_end;
    logic [AW-1:0] n_bytes_in_use;
    t_rsp          n_out;
    logic [AW-1:0] cfg_ext;
    logic [PW-1:0] cfg_size;
    logic          stage_go, out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign stage_go    = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        cfg_ext = AW'(i_cfg_wr_data);
        if (cfg_ext < AW'(2)) begin
            cfg_size = PW'(2);
        end else if (cfg_ext > RING_MAX) begin
            cfg_size = RING_MAX[PW-1:0];
        end else begin
            cfg_size = cfg_ext[PW-1:0];
        end
    end

    rbsa_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .i_req         (r_in),
        .i_ring_size   (r_ring_size),
        .i_freed_mark  (r_freed_mark),
        .i_write_pos   (r_write_pos),
        .i_wrap_end    (r_wrap_end),
        .i_bytes_in_use(r_bytes_in_use),
        .o_freed_mark  (n_freed_mark),
        .o_write_pos   (n_write_pos),
        .o_wrap_end    (n_wrap_end),
        .o_bytes_in_use(n_bytes_in_use),
        .o_rsp         (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size    <= RING_MAX[PW-1:0];
            r_freed_mark   <= '0;
            r_write_pos    <= PW'(1);
            r_wrap_end     <= RING_MAX[PW-1:0];
            r_bytes_in_use <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_wr_en) begin
                r_ring_size    <= cfg_size;
                r_freed_mark   <= '0;
                r_write_pos    <= PW'(1);
                r_wrap_end     <= cfg_size;
                r_bytes_in_use <= '0;
            end else if (stage_go) begin
                r_freed_mark   <= n_freed_mark;
                r_write_pos    <= n_write_pos;
                r_wrap_end     <= n_wrap_end;
                r_bytes_in_use <= n_bytes_in_use;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (stage_go) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/rbsa_step.sv =====
// rbsa_step: fit test, allocate and release arithmetic for one request
// depends on rbsa_pkg
module rbsa_step import rbsa_pkg::*; #(
    parameter int OFFSET_BITS = 20,
    localparam int PW = OFFSET_BITS + 1,
    localparam int AW = ((PW > CNT_W) ? PW : CNT_W) + 1
) (
    input  t_req          i_req,
    input  logic [PW-1:0] i_ring_size,
    input  logic [PW-1:0] i_freed_mark,
    input  logic [PW-1:0] i_write_pos,
    input  logic [PW-1:0] i_wrap_end,
    input  logic [AW-1:0] i_bytes_in_use,
    output logic [PW-1:0] o_freed_mark,
    output logic [PW-1:0] o_write_pos,
    output logic [PW-1:0] o_wrap_end,
    output logic [AW-1:0] o_bytes_in_use,
    output t_rsp          o_rsp
);

    logic [AW-1:0] rs, fm, wp, we, cnt, stop;
    logic [AW-1:0] fit_start, fit_next, offset;
    logic [AW-1:0] rel_first, rel_end, rel_step, rel_sum;
    logic          fit, rel_ok;
    logic [1:0]    status;

    always_comb begin
        rs   = AW'(i_ring_size);
        fm   = AW'(i_freed_mark);
        wp   = AW'(i_write_pos);
        we   = AW'(i_wrap_end);
        cnt  = AW'(i_req.byte_count);
        stop = wp + cnt;

        // fit test
        fit       = 1'b0;
        fit_start = wp;
        fit_next  = wp;
        if (cnt == '0) begin
            fit = 1'b1;
        end else if (wp > fm) begin
            if (stop < rs) begin
                fit      = 1'b1;
                fit_next = stop;
            end else if (stop == rs) begin
                fit      = (fm != '0);
                fit_next = '0;
            end else begin
                fit       = (cnt < fm);
                fit_start = '0;
                fit_next  = cnt;
            end
        end else begin
            fit      = (stop < fm);
            fit_next = stop;
        end

        // release, with restart at the wrap end mark
        rel_first = fm;
        rel_end   = we;
        rel_step  = cnt;
        if ((we != '0) && (fm == we - AW'(1))) begin
            rel_first = '0;
            rel_step  = cnt - AW'(1);
            rel_end   = rs;
        end
        rel_sum = rel_first + rel_step;
        if (rel_first <= wp) begin
            rel_ok = (rel_sum < wp);
        end else begin
            rel_ok = (rel_sum < rel_end);
        end

        o_freed_mark   = i_freed_mark;
        o_write_pos    = i_write_pos;
        o_wrap_end     = i_wrap_end;
        o_bytes_in_use = i_bytes_in_use;
        status         = ST_OK;
        offset         = wp;

        case (i_req.opcode)
            OP_PROBE: begin
                if (!fit) begin
                    status = ST_NOSPACE;
                end
            end
            OP_ALLOC: begin
                if (!fit) begin
                    status = ST_NOSPACE;
                end else if (cnt != '0) begin
                    if ((fit_start == '0) && (wp != '0) && (fit_next == cnt) && (stop > rs)) begin
                        o_wrap_end = i_write_pos;
                    end
                    offset         = fit_start;
                    o_write_pos    = fit_next[PW-1:0];
                    o_bytes_in_use = i_bytes_in_use + cnt;
                end
            end
            OP_RELEASE: begin
                if (cnt != '0) begin
                    if (rel_ok) begin
                        o_freed_mark   = rel_sum[PW-1:0];
                        o_wrap_end     = rel_end[PW-1:0];
                        o_bytes_in_use = (i_bytes_in_use > cnt) ? i_bytes_in_use - cnt : '0;
                    end else begin
                        status = ST_BADFREE;
                    end
                end
            end
            default: begin
            end
        endcase

        o_rsp.status       = status;
        o_rsp.start_offset = offset[OFS_W-1:0];
        o_rsp.ring_empty   = (o_bytes_in_use == '0);
    end

endmodule

// ===== rtl/rbsa_checker.sv =====
// rbsa_assert_checker: port-level checks of the ring buffer space allocator
// depends on rbsa_pkg; bound to ring_buffer_space_allocator_top
module rbsa_assert_checker import rbsa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out
);

    // held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a result appears only after a request transfer
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without request");

    // requests stall only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request stalled with result side free");

    // status codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == ST_OK) || (o_out.status == ST_NOSPACE)
                        || (o_out.status == ST_BADFREE))
        else $error("unknown status code");

endmodule

bind ring_buffer_space_allocator_top rbsa_assert_checker u_rbsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);
